// ===== hdl/tse_pkg.sv =====
// Shared types and constants of the time-series point encoder.
package tse_pkg;

    localparam logic [1:0] TS_PFX_7  = 2'b10;
    localparam logic [2:0] TS_PFX_9  = 3'b110;
    localparam logic [3:0] TS_PFX_12 = 4'b1110;
    localparam logic [3:0] TS_PFX_32 = 4'b1111;
    localparam logic [1:0] VAL_REUSE = 2'b10;
    localparam logic [1:0] VAL_NEW   = 2'b11;
    localparam logic [4:0] LEAD_MAX  = 5'd31;
    localparam logic signed [63:0] DOD_MIN_7  = -64'sd63;
    localparam logic signed [63:0] DOD_MIN_9  = -64'sd255;
    localparam logic signed [63:0] DOD_MIN_12 = -64'sd2047;
    localparam logic [6:0] CHUNK_MAX = 7'd64;

    typedef enum logic [1:0] {
        VK_RAW,
        VK_ZERO,
        VK_ONE,
        VK_SPLIT
    } vkind_t;

    typedef struct packed {
        logic [63:0] ts_bits;
        logic [6:0]  ts_len;
        logic        ovf;
        vkind_t      kind;
        logic [63:0] xval;
        logic [5:0]  trail;
        logic [6:0]  vlen;
        logic [12:0] ctrl;
        logic [3:0]  ctrl_len;
    } point_rec_t;

    typedef struct packed {
        logic [63:0] bits;
        logic [6:0]  len;
        logic        last;
        logic        ovf;
    } chunk_t;

endpackage

// ===== hdl/tse_fifo.sv =====
// Short register queue of classified points between the front and back parts.
module tse_fifo import tse_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  point_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output point_rec_t head_rec,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    point_rec_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== hdl/tse_front.sv =====
// Front part: accepts points, tracks series state and classifies each code.
module tse_front import tse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_ts,
    input  logic [63:0] in_val,
    input  logic        in_first,
    output logic        push,
    output point_rec_t  push_rec,
    input  logic        q_full
);

    logic        s1_valid_reg;
    logic        s1_first_reg;
    logic [63:0] s1_ts_reg;
    logic [63:0] s1_delta_reg;
    logic [63:0] s1_prev_delta_reg;
    logic [63:0] s1_x_reg;

    logic [63:0] last_ts_reg;
    logic [63:0] last_delta_reg;
    logic [63:0] last_val_reg;
    logic [4:0]  win_lead_reg;
    logic [6:0]  win_len_reg;
    logic        win_valid_reg;

    logic               accept;
    logic [63:0]        delta;
    logic [63:0]        dodu;
    logic signed [63:0] dod;
    logic [6:0]         f7;
    logic [8:0]         f9;
    logic [11:0]        f12;
    logic [31:0]        f32;
    logic [63:0]        ts_bits;
    logic [6:0]         ts_len;
    logic               ts_ovf;
    logic [4:0]         lead;
    logic [5:0]         trail;
    logic [6:0]         vlen;
    logic               x_zero;
    logic               win_match;
    logic [12:0]        ctrl;
    logic [3:0]         ctrl_len;
    logic [7:0]         total_len;

    function automatic logic [4:0] lead_count(input logic [63:0] x);
        logic [4:0] n;
        logic       found;
        n     = LEAD_MAX;
        found = 1'b0;
        for (int i = 0; i < 31; i++) begin
            if (!found && x[63 - i]) begin
                n     = 5'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] trail_count(input logic [63:0] x);
        logic [5:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 0; i < 64; i++) begin
            if (!found && x[i]) begin
                n     = 6'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !q_full;
    assign delta    = in_ts - last_ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            last_ts_reg    <= '0;
            last_delta_reg <= '0;
            last_val_reg   <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                last_ts_reg  <= in_ts;
                last_val_reg <= in_val;
                last_delta_reg <= in_first ? 64'd0 : delta;
            end else if (push) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_first_reg      <= in_first;
            s1_ts_reg         <= in_ts;
            s1_delta_reg      <= delta;
            s1_prev_delta_reg <= last_delta_reg;
            s1_x_reg          <= in_first ? in_val : (in_val ^ last_val_reg);
        end
    end

    assign dodu = s1_delta_reg - s1_prev_delta_reg;
    assign dod  = signed'(dodu);
    assign f7   = (dodu == 64'd64)         ? 7'd0  : dodu[6:0];
    assign f9   = (dodu == 64'd256)        ? 9'd0  : dodu[8:0];
    assign f12  = (dodu == 64'd2048)       ? 12'd0 : dodu[11:0];
    assign f32  = (dodu == 64'h8000_0000)  ? 32'd0 : dodu[31:0];

    always_comb begin
        ts_ovf = 1'b0;
        priority if (dod == 64'sd0) begin
            ts_bits = '0;
            ts_len  = 7'd1;
        end else if (dod >= DOD_MIN_7 && dod <= 64'sd64) begin
            ts_bits = {55'd0, TS_PFX_7, f7};
            ts_len  = 7'd9;
        end else if (dod >= DOD_MIN_9 && dod <= 64'sd256) begin
            ts_bits = {52'd0, TS_PFX_9, f9};
            ts_len  = 7'd12;
        end else if (dod >= DOD_MIN_12 && dod <= 64'sd2048) begin
            ts_bits = {48'd0, TS_PFX_12, f12};
            ts_len  = 7'd16;
        end else begin
            ts_bits = {28'd0, TS_PFX_32, f32};
            ts_len  = 7'd36;
            ts_ovf  = (dod < -64'sh8000_0000) || (dod > 64'sh8000_0000);
        end
    end

    assign x_zero    = (s1_x_reg == '0);
    assign lead      = lead_count(s1_x_reg);
    assign trail     = trail_count(s1_x_reg);
    assign vlen      = CHUNK_MAX - 7'(lead) - 7'(trail);
    assign win_match = win_valid_reg && (lead == win_lead_reg) && (vlen == win_len_reg);
    assign ctrl      = win_match ? {11'd0, VAL_REUSE} : {VAL_NEW, lead, 6'(vlen - 7'd1)};
    assign ctrl_len  = win_match ? 4'd2 : 4'd13;
    assign total_len = {1'b0, vlen} + 8'(ctrl_len);

    always_comb begin
        push_rec.ts_bits  = ts_bits;
        push_rec.ts_len   = ts_len;
        push_rec.ovf      = ts_ovf;
        push_rec.xval     = s1_x_reg;
        push_rec.trail    = trail;
        push_rec.vlen     = vlen;
        push_rec.ctrl     = ctrl;
        push_rec.ctrl_len = ctrl_len;
        if (s1_first_reg) begin
            push_rec.ts_bits = s1_ts_reg;
            push_rec.ts_len  = CHUNK_MAX;
            push_rec.ovf     = 1'b0;
            push_rec.kind    = VK_RAW;
            push_rec.trail   = '0;
            push_rec.vlen    = CHUNK_MAX;
        end else if (x_zero) begin
            push_rec.kind = VK_ZERO;
        end else if (total_len <= 8'(CHUNK_MAX)) begin
            push_rec.kind = VK_ONE;
        end else begin
            push_rec.kind = VK_SPLIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
            win_lead_reg  <= '0;
            win_len_reg   <= '0;
        end else if (push) begin
            if (s1_first_reg) begin
                win_valid_reg <= 1'b0;
                win_lead_reg  <= '0;
                win_len_reg   <= '0;
            end else if (!x_zero && !win_match) begin
                win_valid_reg <= 1'b1;
                win_lead_reg  <= lead;
                win_len_reg   <= vlen;
            end
        end
    end

endmodule

// ===== hdl/tse_back.sv =====
// Back part: aligns the value payload and sends each point as two or three chunks.
module tse_back import tse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  point_rec_t q_rec,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output chunk_t     out_chunk
);

    point_rec_t  work_reg;
    logic [63:0] payload_reg;
    logic        work_valid_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    chunk_t      out_chunk_reg;

    logic   out_free;
    logic   emit;
    chunk_t chunk;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = work_valid_reg && out_free;
    assign q_pop     = !q_empty && (!work_valid_reg || (emit && chunk.last));
    assign out_valid = out_valid_reg;
    assign out_chunk = out_chunk_reg;

    always_comb begin
        chunk = '{bits: '0, len: 7'd1, last: 1'b0, ovf: 1'b0};
        if (idx_reg == 2'd0) begin
            chunk.bits = work_reg.ts_bits;
            chunk.len  = work_reg.ts_len;
            chunk.ovf  = work_reg.ovf;
        end else if (idx_reg == 2'd1) begin
            unique case (work_reg.kind)
                VK_RAW: begin
                    chunk.bits = payload_reg;
                    chunk.len  = work_reg.vlen;
                    chunk.last = 1'b1;
                end
                VK_ZERO: begin
                    chunk.last = 1'b1;
                end
                VK_ONE: begin
                    chunk.bits = (64'(work_reg.ctrl) << work_reg.vlen) | payload_reg;
                    chunk.len  = 7'(work_reg.ctrl_len) + work_reg.vlen;
                    chunk.last = 1'b1;
                end
                VK_SPLIT: begin
                    chunk.bits = 64'(work_reg.ctrl);
                    chunk.len  = 7'(work_reg.ctrl_len);
                end
                default: begin
                    chunk.last = 1'b1;
                end
            endcase
        end else begin
            chunk.bits = payload_reg;
            chunk.len  = work_reg.vlen;
            chunk.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                work_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end else if (emit) begin
                if (chunk.last) begin
                    work_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg    <= q_rec;
            payload_reg <= q_rec.xval >> q_rec.trail;
        end
        if (emit) begin
            out_chunk_reg <= chunk;
        end
    end

endmodule

// ===== hdl/time_series_point_encoder_top.sv =====
// A point passes the front stage register, the queue, the work register and the output register.
// The output register sends one chunk per cycle while m_tready is high and points are queued.
// The back part's chunk sequencer sends two chunks per point, three for a split value code.
// The queue of QUEUE_DEPTH points lets the front keep accepting while the output stalls.
// Synchronous active-low reset clears all series state, the window and every valid flag.
module time_series_point_encoder_top import tse_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // timestamp [63:0], sample_bits [127:64]
    input  logic [0:0]   s_tuser,  // first_point [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // code_bits [63:0], code_length [70:64], zero [71]
    output logic [0:0]   m_tuser,  // dod_overflow [0]
    output logic         m_tlast
);

    logic       push;
    point_rec_t push_rec;
    logic       q_full;
    logic       q_pop;
    point_rec_t head_rec;
    logic       q_empty;
    chunk_t     out_chunk;

    tse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ts    (s_tdata[63:0]),
        .in_val   (s_tdata[127:64]),
        .in_first (s_tuser[0]),
        .push     (push),
        .push_rec (push_rec),
        .q_full   (q_full)
    );

    tse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty)
    );

    tse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rec     (head_rec),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_chunk (out_chunk)
    );

    assign m_tdata = {1'b0, out_chunk.len, out_chunk.bits};
    assign m_tuser = out_chunk.ovf;
    assign m_tlast = out_chunk.last;

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[70:64] != 7'd0) && (m_tdata[70:64] <= CHUNK_MAX))
        else $error("chunk length out of range");

    a_ovf_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[70:64] == 7'd36) && !m_tlast)
        else $error("overflow flag on a chunk that is not a long timestamp code");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("queue written while full");

endmodule

// ===== test/testbench.sv =====
// Testbench for the time-series point encoder: directed and random points checked chunk by chunk.
`timescale 1ns / 1ps

class point_code_board;
    tse_pkg::chunk_t pending_chunks[$];
    int mismatches;
    logic [63:0] ts_prev;
    logic [63:0] delta_prev;
    logic [63:0] val_prev;
    logic [4:0] win_lead;
    logic [6:0] win_len;
    logic win_ok;

    function new();
        mismatches = 0;
        ts_prev = '0;
        delta_prev = '0;
        val_prev = '0;
        win_lead = '0;
        win_len = '0;
        win_ok = 1'b0;
    endfunction

    function void push_chunk(logic [63:0] bits, logic [6:0] len, logic last, logic ovf);
        tse_pkg::chunk_t c;
        c.bits = bits;
        c.len = len;
        c.last = last;
        c.ovf = ovf;
        pending_chunks.push_back(c);
    endfunction

    function logic [63:0] dod_field(logic [63:0] dod, int n);
        logic [63:0] top;
        logic [63:0] mask;
        top = 64'd1 << (n - 1);
        mask = (64'd1 << n) - 64'd1;
        return (dod == top) ? 64'd0 : (dod & mask);
    endfunction

    function void note_point(logic [63:0] ts, logic [63:0] val, logic first);
        logic [63:0] delta;
        logic signed [63:0] dod;
        logic [63:0] x;
        logic [63:0] payload;
        logic [12:0] ctrl;
        logic [4:0] lead5;
        logic [5:0] len_m1;
        logic ovf;
        int lead;
        int trail;
        int len;
        int ctrl_len;
        if (first) begin
            push_chunk(ts, 7'd64, 1'b0, 1'b0);
            push_chunk(val, 7'd64, 1'b1, 1'b0);
            ts_prev = ts;
            delta_prev = '0;
            val_prev = val;
            win_ok = 1'b0;
            win_lead = '0;
            win_len = '0;
            return;
        end
        delta = ts - ts_prev;
        dod = delta - delta_prev;
        ovf = 1'b0;
        if (dod == 0) begin
            push_chunk(64'd0, 7'd1, 1'b0, 1'b0);
        end else if (dod >= tse_pkg::DOD_MIN_7 && dod <= 64'sd64) begin
            push_chunk({55'd0, tse_pkg::TS_PFX_7, 7'd0} | dod_field(dod, 7), 7'd9, 1'b0, 1'b0);
        end else if (dod >= tse_pkg::DOD_MIN_9 && dod <= 64'sd256) begin
            push_chunk({52'd0, tse_pkg::TS_PFX_9, 9'd0} | dod_field(dod, 9), 7'd12, 1'b0,
                       1'b0);
        end else if (dod >= tse_pkg::DOD_MIN_12 && dod <= 64'sd2048) begin
            push_chunk({48'd0, tse_pkg::TS_PFX_12, 12'd0} | dod_field(dod, 12), 7'd16, 1'b0,
                       1'b0);
        end else begin
            if (dod < -64'sd2147483648 || dod > 64'sd2147483648)
                ovf = 1'b1;
            push_chunk({28'd0, tse_pkg::TS_PFX_32, 32'd0} | dod_field(dod, 32), 7'd36, 1'b0,
                       ovf);
        end
        delta_prev = delta;
        ts_prev = ts;

        x = val ^ val_prev;
        val_prev = val;
        if (x == 64'd0) begin
            push_chunk(64'd0, 7'd1, 1'b1, 1'b0);
            return;
        end
        lead = 0;
        while (lead < 31 && !x[63 - lead])
            lead++;
        trail = 0;
        while (!x[trail])
            trail++;
        len = 64 - lead - trail;
        payload = x >> trail;
        lead5 = 5'(lead);
        len_m1 = 6'(len - 1);
        if (win_ok && lead5 == win_lead && len == win_len) begin
            ctrl = {11'd0, tse_pkg::VAL_REUSE};
            ctrl_len = 2;
        end else begin
            ctrl = {tse_pkg::VAL_NEW, lead5, len_m1};
            ctrl_len = 13;
            win_lead = lead5;
            win_len = 7'(len);
            win_ok = 1'b1;
        end
        if (ctrl_len + len <= 64) begin
            push_chunk(({51'd0, ctrl} << len) | payload, 7'(ctrl_len + len), 1'b1, 1'b0);
        end else begin
            push_chunk({51'd0, ctrl}, 7'(ctrl_len), 1'b0, 1'b0);
            push_chunk(payload, 7'(len), 1'b1, 1'b0);
        end
    endfunction

    function void check_chunk(logic [71:0] data, logic ovf, logic last);
        tse_pkg::chunk_t want;
        if (pending_chunks.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected chunk, expected none, actual bits %h len %0d",
                     $time, data[63:0], data[70:64]);
            return;
        end
        want = pending_chunks.pop_front();
        if (data[63:0] !== want.bits) begin
            mismatches++;
            $display("%0t: code_bits expected %h actual %h", $time, want.bits, data[63:0]);
        end
        if (data[70:64] !== want.len) begin
            mismatches++;
            $display("%0t: code_length expected %0d actual %0d", $time, want.len, data[70:64]);
        end
        if (data[71] !== 1'b0) begin
            mismatches++;
            $display("%0t: pad bit expected 0 actual %b", $time, data[71]);
        end
        if (last !== want.last) begin
            mismatches++;
            $display("%0t: last_of_point expected %b actual %b", $time, want.last, last);
        end
        if (ovf !== want.ovf) begin
            mismatches++;
            $display("%0t: dod_overflow expected %b actual %b", $time, want.ovf, ovf);
        end
    endfunction
endclass

module testbench;
    import tse_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [127:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [71:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;
    logic calm;

    point_code_board board;
    int quiet_cycles = 0;

    logic [63:0] gen_ts;
    logic [63:0] gen_delta;
    logic [63:0] gen_val;
    int mask_hi;
    int mask_lo;

    logic [63:0] dod_edges [16] = '{
        -64'sd63, 64'sd64, -64'sd64, 64'sd65, -64'sd255, 64'sd256, -64'sd256, 64'sd257,
        -64'sd2047, 64'sd2048, -64'sd2048, 64'sd2049, 64'sd2147483648, -64'sd2147483648,
        64'sd2147483649, -64'sd2147483649
    };

    time_series_point_encoder_top u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_point(s_tdata[63:0], s_tdata[127:64], s_tuser[0]);
        if (aresetn && m_tvalid && m_tready)
            board.check_chunk(m_tdata, m_tuser[0], m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int cyc;
        int hold_left;
        m_tready <= 1'b0;
        cyc = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 400)
                hold_left = 300;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 32);
            end
        end
    end

    task automatic send_point(input logic [63:0] ts, input logic [63:0] val, input logic first);
        while (!calm && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {val, ts};
        s_tuser <= first;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_first(input logic [63:0] ts, input logic [63:0] val);
        gen_ts = ts;
        gen_delta = '0;
        gen_val = val;
        send_point(ts, val, 1'b1);
    endtask

    task automatic send_next(input logic [63:0] dod, input logic [63:0] xmask);
        gen_delta = gen_delta + dod;
        gen_ts = gen_ts + gen_delta;
        gen_val = gen_val ^ xmask;
        send_point(gen_ts, gen_val, 1'b0);
    endtask

    function automatic logic [63:0] shaped_mask(int hi, int lo);
        logic [63:0] span;
        span = ((64'd1 << (hi - lo + 1)) - 64'd1) << lo;
        return ({$urandom, $urandom} & span) | (64'd1 << hi) | (64'd1 << lo);
    endfunction

    initial begin
        logic signed [63:0] dod;
        logic signed [31:0] word;
        logic [63:0] xmask;
        int pick;
        board = new();
        calm <= 1'b0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        gen_ts = '0;
        gen_delta = '0;
        gen_val = '0;
        mask_hi = 40;
        mask_lo = 8;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_next(64'd5, 64'h1);
        send_first(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_next(64'd0, 64'h0);
        send_next(64'd64, 64'h1);
        send_next(-64'sd63, 64'h1);
        send_next(-64'sd64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_next(64'd256, 64'h8000_0000_0000_0001);
        send_next(-64'sd255, 64'h4000_0000_0000_0001);
        send_next(64'd257, 64'h4000_0000_0000_0001);
        send_next(-64'sd256, 64'h0000_0000_0000_0100);
        send_next(64'd2048, 64'h7FFF_FFFF_FFFF_FFFF);
        send_next(-64'sd2047, 64'h0008_0000_0000_0000);
        send_next(64'd2049, 64'h0);
        send_next(-64'sd2048, 64'h0000_0001_0000_0000);
        send_next(64'd2147483648, 64'h0000_0001_0000_0000);
        send_next(-64'sd2147483648, 64'h00F0_0000_0000_0000);
        send_next(64'd2147483649, 64'h0000_0000_8000_0000);
        send_next(-64'sd2147483649, 64'h0);
        send_next(64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
        send_next(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        send_first(64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        send_next(64'd1, 64'h0);
        send_next(64'd1, 64'h0);
        send_next(64'd0, 64'hFFFF_FFFF_0000_0000);

        for (int i = 0; i < 420; i++) begin
            calm <= (i >= 150 && i < 250);
            if ($urandom_range(0, 24) == 0) begin
                send_first({$urandom, $urandom}, {$urandom, $urandom});
                continue;
            end
            pick = $urandom_range(0, 9);
            case (pick)
                1, 2: begin
                    dod = 64'($urandom_range(0, 127));
                    dod = dod - 63;
                end
                3: begin
                    dod = 64'($urandom_range(0, 511));
                    dod = dod - 255;
                end
                4: begin
                    dod = 64'($urandom_range(0, 4095));
                    dod = dod - 2047;
                end
                5, 6: begin
                    word = $urandom;
                    dod = 64'(word);
                end
                7: dod = {$urandom, $urandom};
                8: dod = dod_edges[$urandom_range(0, 15)];
                default: dod = '0;
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: xmask = 64'h0;
                2, 3, 4: xmask = shaped_mask(mask_hi, mask_lo);
                5, 6, 7: begin
                    if ($urandom_range(0, 3) == 0) begin
                        mask_lo = $urandom_range(0, 1);
                        mask_hi = $urandom_range(62, 63);
                    end else begin
                        mask_lo = $urandom_range(0, 63);
                        mask_hi = $urandom_range(mask_lo, 63);
                    end
                    xmask = shaped_mask(mask_hi, mask_lo);
                end
                8: xmask = {$urandom, $urandom};
                default: begin
                    mask_hi = $urandom_range(0, 31);
                    mask_lo = $urandom_range(0, mask_hi);
                    xmask = shaped_mask(mask_hi, mask_lo);
                end
            endcase
            send_next(dod, xmask);
        end
        s_tvalid <= 1'b0;
        calm <= 1'b0;

        @(posedge aclk);
        while (board.pending_chunks.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/tse_pkg.sv
hdl/tse_fifo.sv
hdl/tse_front.sv
hdl/tse_back.sv
hdl/time_series_point_encoder_top.sv
test/testbench.sv
